// ===== rtl/core/permission_mode_string_apply_top_macros.svh =====
// assertion macros for the permission mode string block checker
`ifndef PERMISSION_MODE_STRING_APPLY_TOP_MACROS_SVH
`define PERMISSION_MODE_STRING_APPLY_TOP_MACROS_SVH

// checked only outside reset
`define PMSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define PMSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/pmsa_pkg.sv =====
// types and constants shared by the permission mode string block
package pmsa_pkg;

  localparam int ModeW = 12;
  localparam int PermW = 9;

  localparam logic [PermW-1:0] ALL_BITS = 9'o777;
  localparam logic [PermW-1:0] R_BITS   = 9'o444;
  localparam logic [PermW-1:0] W_BITS   = 9'o222;
  localparam logic [PermW-1:0] X_BITS   = 9'o111;
  localparam logic [PermW-1:0] USR_BITS = 9'o700;
  localparam logic [PermW-1:0] GRP_BITS = 9'o070;
  localparam logic [PermW-1:0] OTH_BITS = 9'o007;

  localparam logic [PermW-1:0] UMASK_RESET = 9'o022;

  // ascii codes
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef enum logic [2:0] {
    PH_START,
    PH_NUM,
    PH_WHO_FRESH,
    PH_WHO,
    PH_OPVAL,
    PH_RWX,
    PH_COPY
  } pmsa_phase_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PLUS,
    OP_MINUS,
    OP_EQ
  } pmsa_op_t;

  typedef struct packed {
    logic [7:0]       ch;
    logic             last;
    logic [ModeW-1:0] old_mode;
  } char_beat_t;

  typedef struct packed {
    logic [ModeW-1:0] new_mode;
    logic             bad_string;
  } res_beat_t;

  typedef struct packed {
    pmsa_phase_t      phase;
    logic [ModeW-1:0] mode_acc;
    logic [ModeW-1:0] start_mode;
    logic [PermW-1:0] who_mask;
    pmsa_op_t         pending_op;
    logic [PermW-1:0] pending_value;
    logic             pending_is_copy;
    logic [ModeW-1:0] octal_value;
    logic [2:0]       digit_count;
    logic             leading_zero;
    logic             error_seen;
  } pmsa_state_t;

endpackage

// ===== rtl/core/pmsa_step.sv =====
// parse step: next parser state and result for one character
module pmsa_step import pmsa_pkg::*; (
  input  pmsa_state_t       state,
  input  char_beat_t        beat,
  input  logic [PermW-1:0]  umask_bits,
  output pmsa_state_t       state_next,
  output res_beat_t         result
);

  function automatic pmsa_op_t op_decode(input logic [7:0] c);
    pmsa_op_t r;
    case (c)
      CH_PLUS:  r = OP_PLUS;
      CH_MINUS: r = OP_MINUS;
      CH_EQ:    r = OP_EQ;
      default:  r = OP_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [PermW-1:0] class_decode(input logic [7:0] c);
    logic [PermW-1:0] r;
    case (c)
      CH_U:    r = USR_BITS;
      CH_G:    r = GRP_BITS;
      CH_O:    r = OTH_BITS;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [PermW-1:0] rwx_decode(input logic [7:0] c);
    logic [PermW-1:0] r;
    case (c)
      CH_R:    r = R_BITS;
      CH_W:    r = W_BITS;
      CH_X:    r = X_BITS;
      default: r = '0;
    endcase
    return r;
  endfunction

  // apply the pending operation to the running mode
  function automatic logic [ModeW-1:0] commit(input pmsa_state_t s,
                                              input logic [PermW-1:0] umask);
    logic [PermW-1:0] v;
    logic [ModeW-1:0] m;
    v = s.pending_value;
    m = s.mode_acc;
    if (s.pending_is_copy) begin
      v = v & m[PermW-1:0];
      if ((v & R_BITS) != '0) v = v | R_BITS;
      if ((v & W_BITS) != '0) v = v | W_BITS;
      if ((v & X_BITS) != '0) v = v | X_BITS;
    end
    if (s.who_mask != '0) v = v & s.who_mask;
    else v = v & ~umask;
    case (s.pending_op)
      OP_EQ:    m = {m[ModeW-1:PermW], (m[PermW-1:0] & ~s.who_mask) | v};
      OP_PLUS:  m = {m[ModeW-1:PermW], m[PermW-1:0] | v};
      OP_MINUS: m = {m[ModeW-1:PermW], m[PermW-1:0] & ~v};
      default:  m = m;
    endcase
    return m;
  endfunction

  pmsa_state_t      s;
  pmsa_op_t         op;
  logic [PermW-1:0] cls;
  logic [PermW-1:0] rwx;
  logic             is_digit;
  logic             lz_eff;

  assign op       = op_decode(beat.ch);
  assign cls      = class_decode(beat.ch);
  assign rwx      = rwx_decode(beat.ch);
  assign is_digit = (beat.ch >= CH_0) && (beat.ch <= CH_9);

  always_comb begin
    s      = state;
    lz_eff = 1'b0;

    // first character of a string
    if (s.phase == PH_START) begin
      s.start_mode      = beat.old_mode;
      s.mode_acc        = beat.old_mode;
      s.who_mask        = '0;
      s.pending_op      = OP_NONE;
      s.pending_value   = '0;
      s.pending_is_copy = 1'b0;
      s.octal_value     = '0;
      s.digit_count     = '0;
      s.leading_zero    = 1'b0;
      s.error_seen      = 1'b0;
      s.phase           = is_digit ? PH_NUM : PH_WHO;
    end

    if (!s.error_seen) begin
      if (s.phase == PH_NUM) begin
        if (beat.ch < CH_0 || beat.ch > CH_7) begin
          s.error_seen = 1'b1;
        end else begin
          lz_eff = (s.digit_count == '0) ? (beat.ch == CH_0) : s.leading_zero;
          s.leading_zero = lz_eff;
          if (s.digit_count >= 3'd4 || (s.digit_count == 3'd3 && !lz_eff)) begin
            s.error_seen = 1'b1;
          end else begin
            s.digit_count = s.digit_count + 3'd1;
            s.octal_value = {s.octal_value[ModeW-4:0], beat.ch[2:0]};
          end
        end
      end else if (s.phase == PH_WHO || s.phase == PH_WHO_FRESH) begin
        if (beat.ch == CH_A) begin
          s.who_mask = ALL_BITS;
          s.phase    = PH_WHO;
        end else if (cls != '0) begin
          s.who_mask = s.who_mask | cls;
          s.phase    = PH_WHO;
        end else if (op != OP_NONE) begin
          s.pending_op      = op;
          s.pending_value   = '0;
          s.pending_is_copy = 1'b0;
          s.phase           = PH_OPVAL;
        end else begin
          s.error_seen = 1'b1;
        end
      end else begin
        if (op != OP_NONE) begin
          s.mode_acc        = commit(s, umask_bits);
          s.pending_op      = op;
          s.pending_value   = '0;
          s.pending_is_copy = 1'b0;
          s.phase           = PH_OPVAL;
        end else if (beat.ch == CH_COMMA) begin
          s.mode_acc = commit(s, umask_bits);
          s.who_mask = '0;
          s.phase    = PH_WHO_FRESH;
        end else if (s.phase != PH_COPY && rwx != '0) begin
          s.pending_value = s.pending_value | rwx;
          s.phase         = PH_RWX;
        end else if (s.phase == PH_OPVAL && cls != '0) begin
          s.pending_value   = cls;
          s.pending_is_copy = 1'b1;
          s.phase           = PH_COPY;
        end else begin
          s.error_seen = 1'b1;
        end
      end
    end

    // end of string: close the open clause or numeric value
    if (beat.last) begin
      if (!s.error_seen) begin
        if (s.phase == PH_NUM) begin
          s.mode_acc = {s.mode_acc[ModeW-1:PermW], s.octal_value[PermW-1:0]};
        end else if (s.phase == PH_WHO) begin
          s.error_seen = 1'b1;
        end else if (s.phase == PH_OPVAL || s.phase == PH_RWX || s.phase == PH_COPY) begin
          s.mode_acc = commit(s, umask_bits);
        end
      end
    end

    result.new_mode   = s.error_seen ? s.start_mode : s.mode_acc;
    result.bad_string = s.error_seen;

    if (beat.last) s.phase = PH_START;
    state_next = s;
  end

endmodule

// ===== rtl/core/permission_mode_string_apply_top.sv =====
// top level of the permission mode string block
// applies a chmod-style mode string to a 12-bit file mode
//
// char channel: char_valid / char_stall / char_beat, one string byte per beat;
//   old_mode is sampled with the first byte of each string, last marks the end
// res channel: res_valid / res_stall / res_beat, one beat per string, sent
//   after the byte marked last: new_mode and bad_string
// cfg: cfg_we writes cfg_wdata into the umask register (reset 0o022); write
//   only while no string is in flight
//
// latency: a last byte accepted at one edge loads the result register at the
//   next edge, so res_valid is up one edge later and the result beat can be
//   taken at the second edge
// throughput: one byte per cycle; the parse step is one pass of decode and
//   mask logic between the byte register and the result register
// reset: clears the parser back to start of string and drops both registers
// stall: while the result register is full and stalled, the byte register
//   still takes one beat; a non-last byte keeps flowing, a last byte waits
//   there and char_stall rises until the result is taken
module permission_mode_string_apply_top import pmsa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [PermW-1:0] cfg_wdata,
  input  logic             char_valid,
  output logic             char_stall,
  input  char_beat_t       char_beat,
  output logic             res_valid,
  input  logic             res_stall,
  output res_beat_t        res_beat
);

  logic [PermW-1:0] umask_bits;

  // byte register
  logic        hold_valid;
  char_beat_t  hold;

  // parser state
  pmsa_state_t state;
  pmsa_state_t state_next;
  res_beat_t   result;

  logic char_take;
  logic res_free;
  logic advance;

  // result register can take a new beat when empty or being drained
  assign res_free   = !res_valid || !res_stall;
  // non-last bytes never need the result register
  assign advance    = hold_valid && (!hold.last || res_free);
  assign char_stall = hold_valid && !advance;
  assign char_take  = char_valid && !char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      umask_bits <= UMASK_RESET;
    end else if (cfg_we) begin
      umask_bits <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (char_take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_take) begin
      hold <= char_beat;
    end
  end

  pmsa_step u_step (
    .state      (state),
    .beat       (hold),
    .umask_bits (umask_bits),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && hold.last) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold.last) begin
      res_beat <= result;
    end
  end

endmodule

// ===== rtl/core/pmsa_checker.sv =====
// port-level checker for the permission mode string block, with its bind
`include "permission_mode_string_apply_top_macros.svh"

module pmsa_checker import pmsa_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_stall,
  input char_beat_t char_beat,
  input logic       res_valid,
  input logic       res_stall,
  input res_beat_t  res_beat
);

  // a stalled result beat holds
  `PMSA_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res_beat), "result beat changed while stalled")

  // no result right after reset
  `PMSA_ASSERT_ALWAYS(a_rst_empty, rst |=> !res_valid, "result valid right after reset")

  // the byte side only stalls behind a stalled result
  `PMSA_ASSERT(a_stall_cause, char_stall |-> res_valid && res_stall, "byte stall without a stalled result")

  // a fresh result follows an accepted last byte
  `PMSA_ASSERT(a_res_source, $rose(res_valid) |-> $past(char_valid && !char_stall && char_beat.last, 2), "result without a last byte")

endmodule

bind permission_mode_string_apply_top pmsa_checker u_pmsa_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_stall (char_stall),
  .char_beat  (char_beat),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .res_beat   (res_beat)
);

// ===== sim/tb_top.sv =====
// testbench for the permission mode string block: string stimulus, own parser model, beat checks
`timescale 1ns / 100ps

module tb_top;
  import pmsa_pkg::*;

  // generous run limit in clock cycles
  localparam int CYCLE_LIMIT = 200000;
  // cycles to let the block settle before a umask write and at the end
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS = 10;

  // character sets used to build mode strings
  localparam logic [7:0] WHO_CH [4] = '{CH_A, CH_U, CH_G, CH_O};
  localparam logic [7:0] OP_CH [3] = '{CH_PLUS, CH_MINUS, CH_EQ};
  localparam logic [7:0] PERM_CH [3] = '{CH_R, CH_W, CH_X};

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [PermW-1:0] cfg_wdata = '0;
  logic             char_valid = 1'b0;
  logic             char_stall;
  char_beat_t       char_beat = '0;
  logic             res_valid;
  logic             res_stall = 1'b0;
  res_beat_t        res_beat;

  // idle and stall rates in percent, set per test
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  // long receiver hold-off: requested by a test, counted down by the stall process
  int hold_request = 0;
  int hold_left = 0;

  int cycle_count = 0;
  int chars_sent = 0;
  int bad_count = 0;

  // bytes of the string under construction
  logic [7:0] str_buf[$];
  // expected result beats, oldest first
  res_beat_t mode_results_q[$];
  res_beat_t want_beat;

  // parser model state, mirrors the block
  pmsa_phase_t      pr_phase = PH_START;
  logic [ModeW-1:0] pr_mode = '0;
  logic [ModeW-1:0] pr_start = '0;
  logic [PermW-1:0] pr_who = '0;
  pmsa_op_t         pr_op = OP_NONE;
  logic [PermW-1:0] pr_val = '0;
  logic             pr_copy = 1'b0;
  logic [ModeW-1:0] pr_octal = '0;
  int               pr_ndig = 0;
  logic             pr_lead = 1'b0;
  logic             pr_bad = 1'b0;
  logic [PermW-1:0] umask_now = UMASK_RESET;

  permission_mode_string_apply_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_beat  (char_beat),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_beat   (res_beat)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // parser model
  // ---------------------------------------------------------------------------

  function automatic pmsa_op_t op_of(logic [7:0] c);
    case (c)
      CH_PLUS:  return OP_PLUS;
      CH_MINUS: return OP_MINUS;
      CH_EQ:    return OP_EQ;
      default:  return OP_NONE;
    endcase
  endfunction

  function automatic logic [PermW-1:0] class_of(logic [7:0] c);
    case (c)
      CH_U:    return USR_BITS;
      CH_G:    return GRP_BITS;
      CH_O:    return OTH_BITS;
      default: return '0;
    endcase
  endfunction

  function automatic logic [PermW-1:0] perm_of(logic [7:0] c);
    case (c)
      CH_R:    return R_BITS;
      CH_W:    return W_BITS;
      CH_X:    return X_BITS;
      default: return '0;
    endcase
  endfunction

  // apply the finished operation to the running mode
  function automatic void apply_pending_op();
    logic [PermW-1:0] v;
    v = pr_val;
    if (pr_copy) begin
      // copy: keep the source class bits present, then spread each of r, w, x
      v &= pr_mode[PermW-1:0];
      if ((v & R_BITS) != '0) v |= R_BITS;
      if ((v & W_BITS) != '0) v |= W_BITS;
      if ((v & X_BITS) != '0) v |= X_BITS;
    end
    // no class named: umask filters the value
    if (pr_who != '0) v &= pr_who;
    else v &= ~umask_now;
    case (pr_op)
      OP_EQ:    pr_mode = (pr_mode & ~ModeW'(pr_who)) | ModeW'(v);
      OP_PLUS:  pr_mode = pr_mode | ModeW'(v);
      OP_MINUS: pr_mode = pr_mode & ~ModeW'(v);
      default: ;
    endcase
  endfunction

  function automatic void open_op(pmsa_op_t op);
    pr_op = op;
    pr_val = '0;
    pr_copy = 1'b0;
    pr_phase = PH_OPVAL;
  endfunction

  // step the model by one accepted character beat
  function automatic void predict_char(char_beat_t b);
    pmsa_op_t         op;
    logic [PermW-1:0] cls;
    logic [PermW-1:0] perm;
    res_beat_t        r;
    op = op_of(b.ch);
    cls = class_of(b.ch);
    perm = perm_of(b.ch);
    if (pr_phase == PH_START) begin
      pr_start = b.old_mode;
      pr_mode = b.old_mode;
      pr_who = '0;
      pr_op = OP_NONE;
      pr_val = '0;
      pr_copy = 1'b0;
      pr_octal = '0;
      pr_ndig = 0;
      pr_lead = 1'b0;
      pr_bad = 1'b0;
      pr_phase = (b.ch >= CH_0 && b.ch <= CH_9) ? PH_NUM : PH_WHO;
    end
    if (!pr_bad) begin
      if (pr_phase == PH_NUM) begin
        if (b.ch < CH_0 || b.ch > CH_7) begin
          pr_bad = 1'b1;
        end else begin
          if (pr_ndig == 0) pr_lead = (b.ch == CH_0);
          // four digits only behind a leading zero, never five
          if (pr_ndig >= 4 || (pr_ndig == 3 && !pr_lead)) begin
            pr_bad = 1'b1;
          end else begin
            pr_ndig++;
            pr_octal = {pr_octal[ModeW-4:0], b.ch[2:0]};
          end
        end
      end else if (pr_phase == PH_WHO || pr_phase == PH_WHO_FRESH) begin
        if (b.ch == CH_A) begin
          pr_who |= ALL_BITS;
          pr_phase = PH_WHO;
        end else if (cls != '0) begin
          pr_who |= cls;
          pr_phase = PH_WHO;
        end else if (op != OP_NONE) begin
          open_op(op);
        end else begin
          pr_bad = 1'b1;
        end
      end else begin
        if (op != OP_NONE) begin
          apply_pending_op();
          open_op(op);
        end else if (b.ch == CH_COMMA) begin
          apply_pending_op();
          pr_who = '0;
          pr_phase = PH_WHO_FRESH;
        end else if (pr_phase != PH_COPY && perm != '0) begin
          pr_val |= perm;
          pr_phase = PH_RWX;
        end else if (pr_phase == PH_OPVAL && cls != '0) begin
          pr_val = cls;
          pr_copy = 1'b1;
          pr_phase = PH_COPY;
        end else begin
          pr_bad = 1'b1;
        end
      end
    end
    if (b.last) begin
      if (!pr_bad) begin
        case (pr_phase)
          PH_NUM:                    pr_mode = {pr_mode[ModeW-1:PermW], pr_octal[PermW-1:0]};
          PH_WHO:                    pr_bad = 1'b1;
          PH_OPVAL, PH_RWX, PH_COPY: apply_pending_op();
          default: ;
        endcase
      end
      r.new_mode = pr_bad ? pr_start : pr_mode;
      r.bad_string = pr_bad;
      mode_results_q.push_back(r);
      pr_phase = PH_START;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // receiver side
  // ---------------------------------------------------------------------------

  // stall process: random stall at the current rate, or a long counted hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // result checker: every accepted result beat against the oldest expectation
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        if (mode_results_q.size() == 0) begin
          bad_count++;
          if (bad_count <= MAX_REPORTS)
            $display("unexpected result beat: new_mode=%o bad_string=%b",
                     res_beat.new_mode, res_beat.bad_string);
        end else begin
          want_beat = mode_results_q.pop_front();
          if (res_beat.new_mode !== want_beat.new_mode ||
              res_beat.bad_string !== want_beat.bad_string) begin
            bad_count++;
            if (bad_count <= MAX_REPORTS)
              $display("result mismatch: new_mode exp %o got %o, bad_string exp %b got %b",
                       want_beat.new_mode, res_beat.new_mode,
                       want_beat.bad_string, res_beat.bad_string);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one character beat, with a random gap first, and wait for acceptance
  task automatic send_char(input char_beat_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_beat <= b;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    predict_char(b);
  endtask

  // send str_buf as one string; old_mode only matters on the first byte
  task automatic send_buffer(input logic [ModeW-1:0] old_mode);
    char_beat_t b;
    for (int i = 0; i < str_buf.size(); i++) begin
      b.ch = str_buf[i];
      b.last = (i == str_buf.size() - 1);
      b.old_mode = (i == 0) ? old_mode : ModeW'($urandom);
      send_char(b);
      chars_sent++;
    end
  endtask

  task automatic send_text(input string s, input logic [ModeW-1:0] old_mode);
    str_buf.delete();
    for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
    send_buffer(old_mode);
  endtask

  // drop valid, wait for every expected result and let the pipe settle
  task automatic drain_results();
    char_valid <= 1'b0;
    while (mode_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // umask writes only with the block idle
  task automatic write_umask(input logic [PermW-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    umask_now = value;
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // string generation
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pick_noise();
    case ($urandom_range(5))
      0:       return WHO_CH[$urandom_range(3)];
      1:       return OP_CH[$urandom_range(2)];
      2:       return PERM_CH[$urandom_range(2)];
      3:       return CH_COMMA;
      4:       return CH_0 + 8'($urandom_range(9));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // mostly well-formed strings with random content, some broken, some noise
  function automatic void make_mode_string();
    int kind;
    int n;
    int nc;
    int nw;
    int nops;
    int np;
    str_buf.delete();
    kind = $urandom_range(99);
    if (kind < 22) begin
      // numeric: usually legal, four digits mostly behind a zero
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) str_buf.push_back(CH_0 + 8'($urandom_range(7)));
      if (n == 4 && $urandom_range(4) != 0) str_buf[0] = CH_0;
      if ($urandom_range(7) == 0) str_buf.push_back(CH_0 + 8'($urandom_range(7)));
      if ($urandom_range(9) == 0) str_buf[$urandom_range(n - 1)] = CH_9 - 8'($urandom_range(1));
    end else if (kind < 88) begin
      // symbolic clauses: up to two who letters, then one or two operations
      nc = $urandom_range(1, 3);
      for (int c = 0; c < nc; c++) begin
        if (c != 0) str_buf.push_back(CH_COMMA);
        nw = $urandom_range(0, 2);
        for (int i = 0; i < nw; i++) str_buf.push_back(WHO_CH[$urandom_range(3)]);
        nops = $urandom_range(1, 2);
        for (int k = 0; k < nops; k++) begin
          str_buf.push_back(OP_CH[$urandom_range(2)]);
          if ($urandom_range(3) == 0) begin
            str_buf.push_back(WHO_CH[$urandom_range(1, 3)]);
          end else begin
            np = $urandom_range(0, 3);
            for (int i = 0; i < np; i++) str_buf.push_back(PERM_CH[$urandom_range(2)]);
          end
        end
      end
      if ($urandom_range(7) == 0) str_buf.push_back(CH_COMMA);
      if ($urandom_range(11) == 0) str_buf[$urandom_range(str_buf.size() - 1)] = pick_noise();
    end else begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) str_buf.push_back(pick_noise());
    end
  endfunction

  task automatic run_random_strings(input int n_chars);
    int first;
    first = chars_sent;
    while (chars_sent - first < n_chars) begin
      make_mode_string();
      send_buffer(ModeW'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked strings: numeric limits, each operator, copy, error cases
  task automatic test_directed_strings();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_text("0777", 12'hfff);   // four digits behind a leading zero
    send_text("8", 12'h000);      // numeric with an illegal digit
    send_text("1234", 12'hfff);   // four digits, no leading zero
    send_text("u=", 12'hfff);     // operator with nothing after it clears u
    send_text("g+u", 12'o0750);   // copy from the user class
    send_text("a-x,", 12'hfff);   // trailing comma is fine
    send_text("=ux", 12'o0644);   // letter after a copy source
    str_buf.delete();
    str_buf.push_back(8'hff);     // non-ascii byte
    send_buffer(12'hfff);
    send_text("ug", 12'h000);     // ends inside the who field
    send_text("+w", 12'h000);     // no class named, umask applies
    drain_results();
  endtask

  // umask extremes and a couple of middle settings
  task automatic test_umask_settings();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    write_umask('0);
    run_random_strings(70);
    write_umask(ALL_BITS);
    run_random_strings(70);
    write_umask(PermW'($urandom));
    run_random_strings(70);
    write_umask(UMASK_RESET);
    run_random_strings(70);
    drain_results();
  endtask

  task automatic test_steady_flow();
    write_umask(PermW'($urandom));
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    run_random_strings(300);
    drain_results();
  endtask

  task automatic test_sparse_sender();
    write_umask(PermW'($urandom));
    tx_idle_pct = 86;
    rx_stall_pct = 0;
    run_random_strings(250);
    drain_results();
  endtask

  task automatic test_slow_receiver();
    write_umask(PermW'($urandom));
    tx_idle_pct = 0;
    rx_stall_pct = 86;
    run_random_strings(250);
    drain_results();
  endtask

  task automatic test_both_sides_idle();
    write_umask(PermW'($urandom));
    tx_idle_pct = 26;
    rx_stall_pct = 26;
    run_random_strings(250);
    drain_results();
  endtask

  // receiver holds off for a long stretch while beats keep coming,
  // so the result register fills and the char side has to stall
  task automatic test_result_backpressure();
    write_umask(PermW'($urandom));
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_request = 300;
    run_random_strings(120);
    drain_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_strings();
    test_umask_settings();
    test_steady_flow();
    test_sparse_sender();
    test_slow_receiver();
    test_both_sides_idle();
    test_result_backpressure();
    drain_results();
    if (bad_count == 0 && mode_results_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
